// ----- src/bc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bc_pkg;

    localparam int N_W         = 6;
    localparam int COEF_W      = 60;
    localparam int MAX_N_DEF   = 63;
    // product of a coefficient and a factor below 2^N_W
    localparam int PROD_W      = COEF_W + N_W;
    localparam int CNT_W       = $clog2(PROD_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified job handed from the front to the back
    typedef struct packed {
        logic [N_W-1:0] n;
        logic [N_W-1:0] k_eff;       // min(k, n-k)
        logic           direct;      // answer known without rounds
        logic           direct_one;  // direct answer is 1, else 0
    } t_job;

endpackage
`default_nettype wire

// ----- src/bc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bc_front #(
    parameter int MAX_N = bc_pkg::MAX_N_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [bc_pkg::N_W-1:0] i_n_total,
    input  wire logic [bc_pkg::N_W-1:0] i_k_chosen,
    output logic                       o_job_valid,
    input  wire logic                  i_job_ready,
    output bc_pkg::t_job               o_job
);
    import bc_pkg::*;

    logic           r_valid;
    t_job           r_job;
    t_job           n_job;
    logic [N_W-1:0] n_minus_k;

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;
    assign n_minus_k   = i_n_total - i_k_chosen;

    always_comb begin
        n_job.n          = i_n_total;
        n_job.k_eff      = (i_k_chosen > n_minus_k) ? n_minus_k : i_k_chosen;
        n_job.direct     = 1'b0;
        n_job.direct_one = 1'b0;
        priority if (i_n_total > N_W'(MAX_N)) begin
            n_job.direct = 1'b1;
        end else if (i_k_chosen > i_n_total) begin
            n_job.direct = 1'b1;
        end else if (i_k_chosen == '0 || i_k_chosen == i_n_total) begin
            n_job.direct     = 1'b1;
            n_job.direct_one = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule
`default_nettype wire

// ----- src/bc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bc_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire bc_pkg::t_job i_job,
    output logic              o_valid,
    input  wire logic         i_ready,
    output bc_pkg::t_job      o_job
);
    import bc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ----- src/bc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bc_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_job_valid,
    output logic                          o_job_ready,
    input  wire bc_pkg::t_job             i_job,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [bc_pkg::COEF_W-1:0]     o_coefficient
);
    import bc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state            r_state;
    logic [COEF_W-1:0] r_acc;
    logic [PROD_W-1:0] r_prod;     // product, shifted out as quotient shifts in
    logic [N_W-1:0]    r_rem;
    logic [N_W-1:0]    r_div;
    logic [N_W-1:0]    r_n;
    logic [N_W-1:0]    r_k;
    logic [N_W-1:0]    r_i;
    logic [CNT_W-1:0]  r_cnt;

    logic [N_W:0]      rem_sh;
    logic              q_bit;
    logic [N_W:0]      rem_sub;
    logic [PROD_W-1:0] n_prod;
    logic [N_W-1:0]    factor;

    assign o_job_ready   = r_state == ST_IDLE;
    assign o_valid       = r_state == ST_OUT;
    assign o_coefficient = r_acc;

    assign factor  = r_n - r_i;
    assign rem_sh  = {r_rem, r_prod[PROD_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign n_prod  = {r_prod[PROD_W-2:0], q_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_n <= i_job.n;
                        r_k <= i_job.k_eff;
                        r_i <= '0;
                        if (i_job.direct) begin
                            r_acc   <= COEF_W'(i_job.direct_one);
                            r_state <= ST_OUT;
                        end else begin
                            r_acc   <= COEF_W'(1);
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(r_acc) * PROD_W'(factor);
                    r_div   <= r_i + 1'b1;
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(PROD_W - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    r_rem  <= q_bit ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
                    r_prod <= n_prod;
                    if (r_cnt == '0) begin
                        r_acc <= n_prod[COEF_W-1:0];
                        r_i   <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_k) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/binomial_coefficient.sv -----
// Binomial coefficient C(n,k), one 60-bit result word per input word.
// Input channel: i_valid / o_ready carrying i_n_total and i_k_chosen.
// Output channel: o_valid / i_ready carrying o_coefficient.
// k above n gives 0; k of 0 or equal to n gives 1; n above MAX_N gives 0.
// The front stage classifies a word and folds k to min(k, n-k), then
// pushes it into a two-entry queue. The back unit runs k rounds, each a
// 60x6 multiply followed by a bit-serial restoring divide of the 66-bit
// product. Trivial words skip the rounds and go straight to the output.
// Items are worked one at a time in the back unit; the front and queue
// keep accepting up to three more words while it is busy.
// A stalled receiver holds the result in the output register; the back
// unit waits, then the queue fills and o_ready drops.
// Synchronous active-low reset empties the queue and pipeline; no
// result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module binomial_coefficient #(
    parameter int MAX_N = bc_pkg::MAX_N_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [bc_pkg::N_W-1:0]    i_n_total,
    input  wire logic [bc_pkg::N_W-1:0]    i_k_chosen,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bc_pkg::COEF_W-1:0]      o_coefficient
);
    import bc_pkg::*;

    logic front_valid;
    logic front_ready;
    t_job front_job;
    logic queue_valid;
    logic queue_ready;
    t_job queue_job;

    bc_front #(
        .MAX_N(MAX_N)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_n_total  (i_n_total),
        .i_k_chosen (i_k_chosen),
        .o_job_valid(front_valid),
        .i_job_ready(front_ready),
        .o_job      (front_job)
    );

    bc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(front_valid),
        .o_ready(front_ready),
        .i_job  (front_job),
        .o_valid(queue_valid),
        .i_ready(queue_ready),
        .o_job  (queue_job)
    );

    bc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (queue_valid),
        .o_job_ready  (queue_ready),
        .i_job        (queue_job),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_coefficient(o_coefficient)
    );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;

    localparam int N_W       = bc_pkg::N_W;
    localparam int COEF_W    = bc_pkg::COEF_W;
    localparam int RAND_CNT  = 268;
    localparam int IDLE_PCT  = 29;
    localparam int CALM_LO   = 120;
    localparam int CALM_HI   = 200;
    localparam int TAIL_CYC  = 2200;
    localparam int MAX_SHOWN = 10;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic [N_W-1:0] k;
        logic           pause;    // hold this word back until all results are in
    } t_query;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic [N_W-1:0]        i_n_total = '0;
    logic [N_W-1:0]        i_k_chosen = '0;
    logic                  i_ready = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [COEF_W-1:0]     o_coefficient;

    t_query                query_q[$];
    logic [COEF_W-1:0]     coef_expect_q[$];
    int                    words_sent = 0;
    int                    words_checked = 0;
    int                    fail_cnt = 0;
    longint                cycle_cnt = 0;

    binomial_coefficient dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_n_total     (i_n_total),
        .i_k_chosen    (i_k_chosen),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_coefficient (o_coefficient)
    );

    always #1 i_clk = ~i_clk;

    // C(n,k) by the multiply / exact-divide rounds on the folded k
    function automatic logic [COEF_W-1:0] n_choose_k(input logic [N_W-1:0] n,
                                                     input logic [N_W-1:0] k);
        logic [COEF_W+N_W+7:0] run;
        int unsigned           rounds;
        int unsigned           r;
        run = 1;
        if (n > bc_pkg::MAX_N_DEF || k > n)
            return '0;
        if (k == 0 || k == n)
            return 1;
        rounds = (k > n - k) ? int'(n - k) : int'(k);
        for (r = 0; r < rounds; r++)
            run = run * (n - r) / (r + 1);
        return run[COEF_W-1:0];
    endfunction

    function automatic t_query make_query(input int n, input int k, input bit pause);
        t_query q;
        q.n = n[N_W-1:0];
        q.k = k[N_W-1:0];
        q.pause = pause;
        return q;
    endfunction

    // word source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                coef_expect_q.push_back(n_choose_k(i_n_total, i_k_chosen));
                words_sent++;
            end
            if (!i_valid || o_ready) begin
                if (query_q.size() > 0
                        && !(query_q[0].pause && coef_expect_q.size() != 0)
                        && ((words_sent >= CALM_LO && words_sent < CALM_HI)
                            || $urandom_range(99) >= IDLE_PCT)) begin
                    i_valid    <= 1'b1;
                    i_n_total  <= query_q[0].n;
                    i_k_chosen <= query_q[0].k;
                    void'(query_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        logic [COEF_W-1:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (coef_expect_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("unexpected result word: coefficient %0d", o_coefficient);
                end else begin
                    want = coef_expect_q.pop_front();
                    if (o_coefficient !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_SHOWN)
                            $display("mismatch at result %0d: coefficient exp %0d got %0d",
                                     words_checked, want, o_coefficient);
                    end
                end
                words_checked++;
            end
            i_ready <= (words_checked >= CALM_LO && words_checked < CALM_HI)
                       || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int n;
        int k;
        int pick;
        int lim;

        // corners: extremes, k above n, k zero / equal to n, fold around n/2
        query_q.push_back(make_query(0, 0, 1'b0));
        query_q.push_back(make_query(63, 63, 1'b0));
        query_q.push_back(make_query(63, 0, 1'b0));
        query_q.push_back(make_query(0, 63, 1'b0));
        query_q.push_back(make_query(63, 31, 1'b0));
        query_q.push_back(make_query(63, 32, 1'b0));
        query_q.push_back(make_query(62, 31, 1'b0));
        query_q.push_back(make_query(1, 0, 1'b0));
        query_q.push_back(make_query(1, 1, 1'b0));
        query_q.push_back(make_query(0, 1, 1'b0));
        query_q.push_back(make_query(5, 6, 1'b0));
        query_q.push_back(make_query(62, 63, 1'b0));
        query_q.push_back(make_query(63, 1, 1'b0));
        query_q.push_back(make_query(63, 62, 1'b0));
        query_q.push_back(make_query(10, 3, 1'b0));
        query_q.push_back(make_query(10, 7, 1'b0));
        query_q.push_back(make_query(2, 1, 1'b0));
        query_q.push_back(make_query(63, 30, 1'b0));
        query_q.push_back(make_query(40, 20, 1'b0));
        query_q.push_back(make_query(42, 21, 1'b0));
        query_q.push_back(make_query(21, 42, 1'b0));
        query_q.push_back(make_query(31, 31, 1'b0));

        for (int i = 0; i < RAND_CNT; i++) begin
            n = $urandom_range(63);
            pick = $urandom_range(99);
            if (pick < 55) begin
                // short runs: k near either end
                lim = (n < 6) ? n : 6;
                k = $urandom_range(lim);
                if ($urandom_range(1))
                    k = n - k;
            end else if (pick < 75) begin
                k = $urandom_range(n);
            end else if (pick < 88 && n < 63) begin
                k = $urandom_range(63, n + 1);
            end else begin
                n = $urandom & 6'h3f;
                k = $urandom & 6'h3f;
            end
            query_q.push_back(make_query(n, k, i == 0 || i % 97 == 50));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (query_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (coef_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        if (coef_expect_q.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/bc_pkg.sv
src/bc_front.sv
src/bc_fifo.sv
src/bc_back.sv
src/binomial_coefficient.sv
verif/tb.sv
